// File: hdl/sensitive_string_classifier_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensitive string classifier
// Concurrent checks, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef SENSITIVE_STRING_CLASSIFIER_ASSERT_SVH
`define SENSITIVE_STRING_CLASSIFIER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check held off while reset is low.
`define SSC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds through reset.
`define SSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SSC_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define SSC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: hdl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, keyword table and helpers for the string classifier.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int MAX_NEEDLE_LEN_DEF = 10;
    localparam int NUM_KEYS           = 12;
    localparam int KEY_MAX_CHARS      = 16;
    localparam int KEY_BITS           = 8 * KEY_MAX_CHARS;

    typedef logic [7:0]          t_byte;
    typedef logic [KEY_BITS-1:0] t_key_text;
    typedef logic [4:0]          t_key_len;

    // Right-aligned: the last character of each keyword sits in bits [7:0].
    localparam t_key_text KEY_TEXT [NUM_KEYS] = '{
        KEY_BITS'("api_key"), KEY_BITS'("apikey"),  KEY_BITS'({"access", "_key"}),
        KEY_BITS'("secret"),  KEY_BITS'("password"), KEY_BITS'("passwd"),
        KEY_BITS'("bearer "), KEY_BITS'("token"),   KEY_BITS'("sk-"),
        KEY_BITS'("ghp_"),    KEY_BITS'("xoxb-"),   KEY_BITS'("akia")
    };

    localparam t_key_len KEY_LEN [NUM_KEYS] = '{
        5'd7, 5'd6, 5'd10, 5'd6, 5'd8, 5'd6, 5'd7, 5'd5, 5'd3, 5'd4, 5'd5, 5'd4
    };

    localparam t_byte CH_AT    = 8'h40;
    localparam t_byte CH_DOT   = 8'h2e;
    localparam t_byte CH_DASH  = 8'h2d;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_ONE   = 8'h31;
    localparam t_byte CH_NINE  = 8'h39;
    localparam t_byte CH_UP_A  = 8'h41;
    localparam t_byte CH_UP_Z  = 8'h5a;
    localparam t_byte CASE_BIT = 8'h20;

    typedef enum logic [2:0] {
        CAT_NONE       = 3'd0,
        CAT_EMAIL      = 3'd1,
        CAT_API_KEY    = 3'd2,
        CAT_PHONE      = 3'd3,
        CAT_IDENTIFIER = 3'd4
    } t_category;

    // Window control handed from the top level to the cell row.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctrl;

    // Byte of keyword k counted back from its last character.
    function automatic t_byte key_byte(input int k, input int off);
        t_key_text txt;
        txt = KEY_TEXT[k];
        return txt[8*off +: 8];
    endfunction

    // Only 'A'..'Z' fold.
    function automatic t_byte to_lower(input t_byte b);
        t_byte r;
        r = b;
        if (b >= CH_UP_A && b <= CH_UP_Z) begin
            r = b | CASE_BIT;
        end
        return r;
    endfunction

endpackage

// File: hdl/sensitive_string_classifier.sv
// ----------------------------------------------------------------------------
// sensitive_string_classifier
// Result: the result of a final byte is registered and on o_valid in the cycle after its beat.
// Throughput: one byte per cycle; the input stalls only while a result beat
//   waits in the output register and the sink holds i_ready low.
// Reset: synchronous, active low; clears window, flags and output valid and
//   sets identifier_min_length to 13. No clearing pass.
// ----------------------------------------------------------------------------
`include "sensitive_string_classifier_assert.svh"

module sensitive_string_classifier #(
    parameter int MAX_NEEDLE_LEN = ssc_pkg::MAX_NEEDLE_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream in
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_byte,
    input  logic        i_end_of_string,
    // classification out
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_category_code,
    output logic        o_is_sensitive,
    output logic        o_hard_flag,
    // register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam logic [15:0] MIN_LEN_RST = 16'd13;
    localparam logic [3:0]  DIGIT_MAX   = 4'd15;
    localparam logic [15:0] LEN_MAX     = 16'hffff;

    // Output register state, used by the handshake below.
    logic               r_out_valid;
    ssc_pkg::t_category r_cat;

    // ------------------------------------------------------------------
    // Beat handshake. A finished result sits in the output register, so a
    // new byte is taken whenever that register is free or drains this cycle.
    // ------------------------------------------------------------------
    logic w_accept;
    logic w_load;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_load   = w_accept && i_end_of_string;

    // Register port never stalls.
    assign o_cfg_ready = 1'b1;

    logic [15:0] r_min_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RST;
        end else if (i_cfg_valid) begin
            r_min_len <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Keyword window: row of cells, shifted on every accepted byte and
    // zeroed after the final byte of a string.
    // ------------------------------------------------------------------
    ssc_pkg::t_byte     w_low;
    ssc_pkg::t_win_ctrl w_win_ctrl;
    logic               w_key_hit;

    assign w_low      = ssc_pkg::to_lower(i_char_byte);
    assign w_win_ctrl = '{shift: w_accept, clear: i_end_of_string};

    ssc_window #(
        .MAX_NEEDLE_LEN (MAX_NEEDLE_LEN)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_win_ctrl),
        .i_cur     (w_low),
        .o_key_hit (w_key_hit)
    );

    // ------------------------------------------------------------------
    // Running flags for the current string.
    // ------------------------------------------------------------------
    logic        r_saw_at,  n_saw_at;
    logic        r_saw_dot, n_saw_dot;
    logic        r_saw_dash, n_saw_dash;
    logic        r_key_seen, n_key_seen;
    logic [3:0]  r_digit_count, n_digit_count;
    logic [1:0]  r_prefix_cnt, n_prefix_cnt;
    logic        r_prefix_broken, n_prefix_broken;
    logic [15:0] r_length, n_length;
    logic        w_is_digit;
    ssc_pkg::t_byte w_want;

    assign w_is_digit = (i_char_byte >= ssc_pkg::CH_ZERO) &&
                        (i_char_byte <= ssc_pkg::CH_NINE);
    // prefix 0,1,0: only the second digit is a one
    assign w_want     = (r_prefix_cnt == 2'd1) ? ssc_pkg::CH_ONE : ssc_pkg::CH_ZERO;

    // Flag values including the current byte.
    always_comb begin
        n_saw_at        = r_saw_at   || (i_char_byte == ssc_pkg::CH_AT);
        n_saw_dot       = r_saw_dot  || (i_char_byte == ssc_pkg::CH_DOT);
        n_saw_dash      = r_saw_dash || (i_char_byte == ssc_pkg::CH_DASH);
        n_key_seen      = r_key_seen || w_key_hit;
        n_digit_count   = r_digit_count;
        n_prefix_cnt    = r_prefix_cnt;
        n_prefix_broken = r_prefix_broken;
        if (w_is_digit) begin
            if (!r_prefix_broken && r_prefix_cnt != 2'd3) begin
                if (i_char_byte == w_want) begin
                    n_prefix_cnt = r_prefix_cnt + 2'd1;
                end else begin
                    n_prefix_broken = 1'b1;
                end
            end
            if (r_digit_count != DIGIT_MAX) begin
                n_digit_count = r_digit_count + 4'd1;
            end
        end
        n_length = (r_length != LEN_MAX) ? r_length + 16'd1 : r_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_load) begin
            r_saw_at        <= 1'b0;
            r_saw_dot       <= 1'b0;
            r_saw_dash      <= 1'b0;
            r_key_seen      <= 1'b0;
            r_digit_count   <= '0;
            r_prefix_cnt    <= '0;
            r_prefix_broken <= 1'b0;
            r_length        <= '0;
        end else if (w_accept) begin
            r_saw_at        <= n_saw_at;
            r_saw_dot       <= n_saw_dot;
            r_saw_dash      <= n_saw_dash;
            r_key_seen      <= n_key_seen;
            r_digit_count   <= n_digit_count;
            r_prefix_cnt    <= n_prefix_cnt;
            r_prefix_broken <= n_prefix_broken;
            r_length        <= n_length;
        end
    end

    // ------------------------------------------------------------------
    // Category in priority order: email, api key, phone, identifier.
    // ------------------------------------------------------------------
    ssc_pkg::t_category w_cat;
    logic               w_phone;

    assign w_phone = ((n_digit_count == 4'd10) || (n_digit_count == 4'd11)) &&
                     (n_prefix_cnt == 2'd3) && !n_prefix_broken;

    always_comb begin
        priority if (n_saw_at && n_saw_dot) begin
            w_cat = ssc_pkg::CAT_EMAIL;
        end else if (n_key_seen) begin
            w_cat = ssc_pkg::CAT_API_KEY;
        end else if (w_phone) begin
            w_cat = ssc_pkg::CAT_PHONE;
        end else if ((n_length >= r_min_len) && n_saw_dash) begin
            w_cat = ssc_pkg::CAT_IDENTIFIER;
        end else begin
            w_cat = ssc_pkg::CAT_NONE;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cat <= w_cat;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_category_code = r_cat;
    assign o_is_sensitive  = (r_cat != ssc_pkg::CAT_NONE);
    assign o_hard_flag     = (r_cat == ssc_pkg::CAT_API_KEY);

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `SSC_ASSERT_RST(a_last_gives_beat, i_clk, i_rst_n, w_load |=> o_valid,
        "final byte gave no result beat")
    `SSC_ASSERT_RST(a_last_clears, i_clk, i_rst_n,
        w_load |=> (r_length == '0 && !r_key_seen && r_digit_count == '0),
        "string state not cleared")
    `SSC_ASSERT_RST(a_no_phantom, i_clk, i_rst_n, (!o_valid && !w_load) |=> !o_valid,
        "result beat without final byte")
    `SSC_ASSERT_RST(a_digit_sat, i_clk, i_rst_n,
        (r_digit_count == DIGIT_MAX && w_accept && !i_end_of_string)
            |=> (r_digit_count == DIGIT_MAX),
        "digit count wrapped")

endmodule

// File: hdl/ssc_cell.sv
// ----------------------------------------------------------------------------
// ssc_cell
// One window slot: holds a lower-cased byte, passes it on, and compares it
// against the keyword byte expected at its distance from the newest byte.
// ----------------------------------------------------------------------------
module ssc_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ssc_pkg::t_win_ctrl             i_ctrl,
    input  ssc_pkg::t_byte                 i_byte,
    output ssc_pkg::t_byte                 o_byte,
    output logic [ssc_pkg::NUM_KEYS-1:0]   o_key_ok
);

    localparam int OFF = CELL_IDX + 1;

    ssc_pkg::t_byte r_byte;
    ssc_pkg::t_byte n_byte;

    assign n_byte = i_ctrl.clear ? '0 : i_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_ctrl.shift) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

    for (genvar k = 0; k < ssc_pkg::NUM_KEYS; k++) begin : g_key
        if (OFF < int'(ssc_pkg::KEY_LEN[k])) begin : g_cmp
            assign o_key_ok[k] = (r_byte == ssc_pkg::key_byte(k, OFF));
        end else begin : g_free
            // keyword is shorter than this distance
            assign o_key_ok[k] = 1'b1;
        end
    end

endmodule

// File: hdl/ssc_window.sv
// ----------------------------------------------------------------------------
// ssc_window
// Row of cells holding the recent lower-cased bytes; flags a keyword that
// ends on the current byte.
// ----------------------------------------------------------------------------
module ssc_window #(
    parameter int MAX_NEEDLE_LEN = ssc_pkg::MAX_NEEDLE_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssc_pkg::t_win_ctrl i_ctrl,
    input  ssc_pkg::t_byte     i_cur,
    output logic               o_key_hit
);

    localparam int WIN_DEPTH = MAX_NEEDLE_LEN - 1;

    ssc_pkg::t_byte                 w_byte [WIN_DEPTH];
    logic [ssc_pkg::NUM_KEYS-1:0]   w_ok   [WIN_DEPTH];
    logic [ssc_pkg::NUM_KEYS-1:0]   w_last;
    logic [ssc_pkg::NUM_KEYS-1:0]   w_hit;

    for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
        ssc_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (i_ctrl),
            .i_byte   ((i == 0) ? i_cur : w_byte[(i == 0) ? 0 : i-1]),
            .o_byte   (w_byte[i]),
            .o_key_ok (w_ok[i])
        );
    end

    // last character of each keyword against the current byte; keywords
    // longer than the window never match
    for (genvar k = 0; k < ssc_pkg::NUM_KEYS; k++) begin : g_last
        if (int'(ssc_pkg::KEY_LEN[k]) <= MAX_NEEDLE_LEN) begin : g_on
            assign w_last[k] = (i_cur == ssc_pkg::key_byte(k, 0));
        end else begin : g_off
            assign w_last[k] = 1'b0;
        end
    end

    always_comb begin
        w_hit = w_last;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            w_hit = w_hit & w_ok[i];
        end
    end

    assign o_key_hit = |w_hit;

endmodule
